/* hdl/cds_pkg.sv */
package cds_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int STAT_W  = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
  localparam int DIV100_MUL_W = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam int Q100_W       = PROD_W - DIV100_SHIFT;

  localparam int ZT_W  = 6;
  localparam int SUM_W = 15;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [STAT_W-1:0]  status;
  } step_t;

  // Length of a month; 0 for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = 5'd31;
    end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (month == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

  // (13 * m + 8) / 5 for the shifted month m in 3..14
  function automatic logic [ZT_W-1:0] month_term(input logic [MONTH_W-1:0] m);
    logic [ZT_W-1:0] t;
    case (m)
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      4'd13:   t = 6'd35;
      4'd14:   t = 6'd38;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

/* hdl/cds_in_if.sv */
interface cds_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [cds_pkg::YEAR_W-1:0]   in_year;
  logic [cds_pkg::MONTH_W-1:0]  in_month;
  logic [cds_pkg::DAY_W-1:0]    in_day;

  modport source (output valid, func, in_year, in_month, in_day, input ready);
  modport sink   (input valid, func, in_year, in_month, in_day, output ready);
endinterface

/* hdl/cds_out_if.sv */
interface cds_out_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::YEAR_W-1:0]   out_year;
  logic [cds_pkg::MONTH_W-1:0]  out_month;
  logic [cds_pkg::DAY_W-1:0]    out_day;
  logic [cds_pkg::WDAY_W-1:0]   weekday;
  logic [cds_pkg::STAT_W-1:0]   status;

  modport source (output valid, out_year, out_month, out_day, weekday, status,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, weekday, status,
                  output ready);
endinterface

/* hdl/cds_step.sv */
module cds_step (
  input  logic            clk,
  input  logic            rst,
  cds_in_if.sink          in_ch,
  output logic            step_valid,
  input  logic            step_ready,
  output cds_pkg::step_t  step_item
);
  import cds_pkg::*;

  // Stage A: capture the word and start the divide by 100
  logic                 a_valid;
  logic                 a_func;
  logic [YEAR_W-1:0]    a_year;
  logic [MONTH_W-1:0]   a_month;
  logic [DAY_W-1:0]     a_day;
  logic [Q100_W-1:0]    a_q100;
  logic                 a_adv;
  logic [PROD_W-1:0]    prod;

  // Stage B: checked and stepped date
  logic                 b_valid;
  step_t                b_item;
  logic                 b_adv;

  logic [YEAR_W-1:0]    r100;
  logic                 leap;
  logic [DAY_W-1:0]     mlen;
  logic                 date_ok;
  step_t                b_next;

  assign b_adv       = !b_valid || step_ready;
  assign a_adv       = !a_valid || b_adv;
  assign in_ch.ready = a_adv;

  assign prod = PROD_W'(in_ch.in_year) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= in_ch.valid;
    end
    if (a_adv) begin
      a_func  <= in_ch.func;
      a_year  <= in_ch.in_year;
      a_month <= in_ch.in_month;
      a_day   <= in_ch.in_day;
      a_q100  <= prod[PROD_W-1:DIV100_SHIFT];
    end
  end

  assign r100 = a_year - YEAR_W'(a_q100) * YEAR_W'(100);
  assign leap = ((a_year[1:0] == 2'd0) && (r100 != '0)) ||
                ((r100 == '0) && (a_q100[1:0] == 2'd0));
  assign mlen = month_len(a_month, leap);
  assign date_ok = (a_year >= YEAR_MIN) && (a_year <= YEAR_MAX) &&
                   (a_day != '0) && (a_day <= mlen);

  always_comb begin
    b_next.year   = a_year;
    b_next.month  = a_month;
    b_next.day    = a_day;
    b_next.status = ST_OK;
    if (!date_ok) begin
      b_next.status = ST_BAD_DATE;
    end else if (!a_func) begin
      if (a_day == mlen) begin
        b_next.day = DAY_W'(1);
        if (a_month == MONTH_DEC) begin
          b_next.month = MONTH_JAN;
          b_next.year  = a_year + YEAR_W'(1);
        end else begin
          b_next.month = a_month + MONTH_W'(1);
        end
      end else begin
        b_next.day = a_day + DAY_W'(1);
      end
    end else begin
      if (a_day == DAY_W'(1)) begin
        if (a_month == MONTH_JAN) begin
          b_next.month = MONTH_DEC;
          b_next.year  = a_year - YEAR_W'(1);
        end else begin
          b_next.month = a_month - MONTH_W'(1);
        end
        // leap of the input year is right: only a step into February needs it
        b_next.day = month_len(b_next.month, leap);
      end else begin
        b_next.day = a_day - DAY_W'(1);
      end
    end
    if (b_next.status == ST_OK &&
        (b_next.year < YEAR_MIN || b_next.year > YEAR_MAX)) begin
      b_next.status = ST_RANGE;
    end
    // echo the input on any error
    if (b_next.status != ST_OK) begin
      b_next.year  = a_year;
      b_next.month = a_month;
      b_next.day   = a_day;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= a_valid;
    end
    if (b_adv) begin
      b_item <= b_next;
    end
  end

  assign step_valid = b_valid;
  assign step_item  = b_item;

  a_ok_date_legal: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_item.status == ST_OK |->
      b_item.day != '0 && b_item.month != '0 && b_item.month <= MONTH_DEC &&
      b_item.year != '0 && b_item.year <= YEAR_MAX)
    else $error("stepped date out of legal range");

  a_range_edge: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_item.status == ST_RANGE |->
      (b_item.year == YEAR_MIN && b_item.month == MONTH_JAN && b_item.day == DAY_W'(1)) ||
      (b_item.year == YEAR_MAX && b_item.month == MONTH_DEC && b_item.day == DAY_W'(31)))
    else $error("range status away from calendar ends");

endmodule

/* hdl/cds_wday.sv */
module cds_wday (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_valid,
  output logic            step_ready,
  input  cds_pkg::step_t  step_item,
  cds_out_if.source       out_ch
);
  import cds_pkg::*;

  // Stage C: shifted year/month and divide by 100
  logic                 c_valid;
  step_t                c_item;
  logic [YEAR_W-1:0]    c_yz;
  logic [MONTH_W-1:0]   c_mz;
  logic [Q100_W-1:0]    c_q100;
  logic                 c_adv;
  logic [YEAR_W-1:0]    yz;
  logic [MONTH_W-1:0]   mz;
  logic [PROD_W-1:0]    prod;

  // Stage D: congruence sum
  logic                 d_valid;
  step_t                d_item;
  logic [SUM_W-1:0]     d_sum;
  logic                 d_adv;
  logic [SUM_W-1:0]     sum;

  // Stage E: output word
  logic                 e_valid;
  step_t                e_item;
  logic [WDAY_W-1:0]    e_wday;
  logic                 e_adv;
  logic [5:0]           fold1;
  logic [3:0]           fold2;
  logic [WDAY_W-1:0]    rem7;

  assign e_adv      = !e_valid || out_ch.ready;
  assign d_adv      = !d_valid || e_adv;
  assign c_adv      = !c_valid || d_adv;
  assign step_ready = c_adv;

  // For a valid date, January and February count as months 13 and 14 of the year before
  always_comb begin
    yz = step_item.year;
    mz = step_item.month;
    if (step_item.status == ST_OK && step_item.month < MONTH_MAR) begin
      yz = step_item.year - YEAR_W'(1);
      mz = step_item.month + MONTH_W'(12);
    end
  end

  assign prod = PROD_W'(yz) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_adv) begin
      c_valid <= step_valid;
    end
    if (c_adv) begin
      c_item <= step_item;
      c_yz   <= yz;
      c_mz   <= mz;
      c_q100 <= prod[PROD_W-1:DIV100_SHIFT];
    end
  end

  assign sum = SUM_W'(c_yz) + SUM_W'(c_yz >> 2) - SUM_W'(c_q100) +
               SUM_W'(c_q100 >> 2) + SUM_W'(month_term(c_mz)) + SUM_W'(c_item.day);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_adv) begin
      d_valid <= c_valid;
    end
    if (d_adv) begin
      d_item <= c_item;
      d_sum  <= sum;
    end
  end

  // 8 = 1 mod 7: fold octal digits, then one conditional subtract
  assign fold1 = 6'(d_sum[2:0]) + 6'(d_sum[5:3]) + 6'(d_sum[8:6]) +
                 6'(d_sum[11:9]) + 6'(d_sum[14:12]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
  assign rem7  = (fold2 >= 4'd7) ? WDAY_W'(fold2 - 4'd7) : WDAY_W'(fold2);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_adv) begin
      e_valid <= d_valid;
    end
    if (e_adv) begin
      e_item <= d_item;
      e_wday <= (d_item.status == ST_OK) ? rem7 : '0;
    end
  end

  assign out_ch.valid     = e_valid;
  assign out_ch.out_year  = e_item.year;
  assign out_ch.out_month = e_item.month;
  assign out_ch.out_day   = e_item.day;
  assign out_ch.weekday   = e_wday;
  assign out_ch.status    = e_item.status;

  a_wday_range: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> e_wday <= WDAY_W'(6))
    else $error("weekday above Saturday");

  a_err_wday_zero: assert property (@(posedge clk) disable iff (rst)
    e_valid && e_item.status != ST_OK |-> e_wday == '0)
    else $error("weekday not cleared on error");

endmodule

/* hdl/calendar_date_step_core.sv */
// Channel  | Dir | Words carried                          | Handshake
// in_ch    | in  | func, in_year, in_month, in_day        | valid/ready
// out_ch   | out | out_year, out_month, out_day,          | valid/ready
//          |     | weekday, status                        |
//
// Five register stages: capture and divide by 100, check and step the date,
// shift the month and divide by 100 again, weekday sum, mod 7 and output.
// One word enters every cycle unless a stalled output has filled the stages.
// Reset (rst, synchronous) clears only the stage valid bits.
// A stalled output holds each full stage with no empty stage ahead of it;
// empty stages keep filling, so no word is dropped or repeated.
module calendar_date_step_core (
  input  logic  clk,
  input  logic  rst,
  cds_in_if.sink    in_ch,
  cds_out_if.source out_ch
);
  import cds_pkg::*;

  // checked and stepped date between the two halves
  logic   step_valid;
  logic   step_ready;
  step_t  step_item;

  // validate the date and roll it one day forward or back
  cds_step u_step (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step_item  (step_item)
  );

  // weekday of the new date and the output register
  cds_wday u_wday (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step_item  (step_item),
    .out_ch     (out_ch)
  );

endmodule
